// ----- hw/rtl/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

    // operations of the shared multiply-reduce unit
    localparam logic OP_MUL = 1'b0;  // (a * b) mod m, shift and add
    localparam logic OP_RED = 1'b1;  // b mod m, one bit per cycle msb first

    typedef struct packed {
        logic start;
        logic op;
    } mm_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/modular_exponentiation.sv -----
`default_nettype none

// modular exponentiation: takes base, exponent and modulus in one input beat and returns
// base^exponent mod modulus in one output beat. the base is first reduced by the modulus
// (msb first, one bit per cycle), then the exponent is scanned from its low bit: every
// bit costs one modular squaring, and a set bit one modular multiply before it. both go
// through a single shared shift-and-add multiply-reduce unit that consumes one multiplier
// bit per cycle. an exponent of zero returns 1 even for a modulus of 1, and a modulus of
// zero returns 0 without using the multiply-reduce unit. the input is taken only while the
// block is idle; a finished result waits in the output register, and the next beat can be
// taken meanwhile.
module modular_exponentiation #(
    parameter int DATA_WIDTH = 31
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // base_value, exponent_value, modulus_value from bit 0 up, zero padded to bytes
    input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // power_result from bit 0 up, zero padded to bytes
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready
);

    localparam int OW = ((DATA_WIDTH + 7) / 8) * 8;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a beat
    localparam logic [2:0] S_RED  = 3'd1;  // launch base reduction
    localparam logic [2:0] S_WRED = 3'd2;  // wait for reduced base
    localparam logic [2:0] S_BIT  = 3'd3;  // look at the next exponent bit
    localparam logic [2:0] S_WACC = 3'd4;  // wait for acc * sq
    localparam logic [2:0] S_WSQ  = 3'd5;  // wait for sq * sq
    localparam logic [2:0] S_FIN  = 3'd6;  // hand the result to the output register

    logic [2:0]            state_reg, state_next;
    logic [DATA_WIDTH-1:0] sq_reg,    sq_next;   // holds the raw base until reduced
    logic [DATA_WIDTH-1:0] acc_reg,   acc_next;
    logic [DATA_WIDTH-1:0] ex_reg,    ex_next;
    logic [DATA_WIDTH-1:0] m_reg,     m_next;
    logic [DATA_WIDTH-1:0] res_reg,   res_next;
    logic                  tvalid_reg, tvalid_next;

    // shared unit hookup
    mme_pkg::mm_ctrl_t     mm_ctrl;
    logic [DATA_WIDTH-1:0] mm_a, mm_b;
    logic [DATA_WIDTH-1:0] mm_result;
    logic                  mm_done;

    logic                  in_beat;
    logic [DATA_WIDTH-1:0] in_base, in_ex, in_mod;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_base       = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_ex         = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_mod        = s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];

    always_comb begin
        state_next    = state_reg;
        sq_next       = sq_reg;
        acc_next      = acc_reg;
        ex_next       = ex_reg;
        m_next        = m_reg;
        res_next      = res_reg;
        tvalid_next   = tvalid_reg && !m_axis_tready;
        mm_ctrl.start = 1'b0;
        mm_ctrl.op    = mme_pkg::OP_MUL;
        // squaring is the default operand pair
        mm_a          = sq_reg;
        mm_b          = sq_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    sq_next  = in_base;
                    ex_next  = in_ex;
                    m_next   = in_mod;
                    // a zero modulus is rejected with a zero result
                    if (in_mod == '0) begin
                        acc_next   = '0;
                        state_next = S_FIN;
                    end else begin
                        acc_next   = DATA_WIDTH'(1);
                        state_next = S_RED;
                    end
                end
            end
            S_RED: begin
                mm_ctrl.start = 1'b1;
                mm_ctrl.op    = mme_pkg::OP_RED;
                state_next    = S_WRED;
            end
            S_WRED: begin
                if (mm_done) begin
                    sq_next    = mm_result;
                    state_next = S_BIT;
                end
            end
            S_BIT: begin
                if (ex_reg == '0) begin
                    state_next = S_FIN;
                end else if (ex_reg[0]) begin
                    mm_ctrl.start = 1'b1;
                    mm_a          = acc_reg;
                    state_next    = S_WACC;
                end else begin
                    mm_ctrl.start = 1'b1;
                    state_next    = S_WSQ;
                end
            end
            S_WACC: begin
                // fold in the product and launch the squaring in the same cycle
                if (mm_done) begin
                    acc_next      = mm_result;
                    mm_ctrl.start = 1'b1;
                    state_next    = S_WSQ;
                end
            end
            S_WSQ: begin
                if (mm_done) begin
                    sq_next    = mm_result;
                    ex_next    = {1'b0, ex_reg[DATA_WIDTH-1:1]};
                    state_next = S_BIT;
                end
            end
            S_FIN: begin
                // load only once the previous result is gone
                if (!tvalid_reg || m_axis_tready) begin
                    res_next    = acc_reg;
                    tvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    mme_mulmod #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mm_ctrl),
        .a       (mm_a),
        .b       (mm_b),
        .m       (m_reg),
        .result  (mm_result),
        .done    (mm_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
        end
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        ex_reg  <= ex_next;
        m_reg   <= m_next;
        res_reg <= res_next;
    end

    assign m_axis_tdata  = OW'(res_reg);
    assign m_axis_tvalid = tvalid_reg;

`ifndef NO_ASSERTIONS
    // the shared unit only reports completion while the sequencer waits for it
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_done |-> (state_reg == S_WRED || state_reg == S_WACC || state_reg == S_WSQ))
        else $error("multiply-reduce unit finished outside a wait state");

    // running values stay reduced between exponent bits when the modulus is above 1
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BIT && m_reg > DATA_WIDTH'(1)) |-> (acc_reg < m_reg && sq_reg < m_reg))
        else $error("running value not reduced by the modulus");

    // a zero modulus goes straight to the result with value zero
    a_zero_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && in_mod == '0) |=> (state_reg == S_FIN && acc_reg == '0))
        else $error("zero modulus not rejected");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mme_mulmod.sv -----
`default_nettype none

module mme_mulmod #(
    parameter int DATA_WIDTH = 31
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire mme_pkg::mm_ctrl_t      ctrl,
    input  wire logic [DATA_WIDTH-1:0]  a,
    input  wire logic [DATA_WIDTH-1:0]  b,
    input  wire logic [DATA_WIDTH-1:0]  m,
    output logic      [DATA_WIDTH-1:0]  result,
    output logic                        done
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  op_reg,   op_next;
    logic [DATA_WIDTH-1:0] acc_reg,  acc_next;
    logic [DATA_WIDTH-1:0] add_reg,  add_next;
    logic [DATA_WIDTH-1:0] b_reg,    b_next;
    logic [DATA_WIDTH-1:0] m_reg,    m_next;
    logic [CW-1:0]         cnt_reg,  cnt_next;

    logic [DATA_WIDTH:0]   s_acc, d_acc, s_add, d_add;
    logic [DATA_WIDTH-1:0] acc_red, add_red;

    // accumulator path: acc + addend in multiply mode, 2*acc + bit in reduce mode
    always_comb begin
        if (op_reg == mme_pkg::OP_RED) begin
            s_acc = {acc_reg, b_reg[DATA_WIDTH-1]};
        end else begin
            s_acc = {1'b0, acc_reg} + {1'b0, (b_reg[0] ? add_reg : '0)};
        end
        d_acc   = s_acc - {1'b0, m_reg};
        acc_red = d_acc[DATA_WIDTH] ? s_acc[DATA_WIDTH-1:0] : d_acc[DATA_WIDTH-1:0];
        s_add   = {1'b0, add_reg} + {1'b0, add_reg};
        d_add   = s_add - {1'b0, m_reg};
        add_red = d_add[DATA_WIDTH] ? s_add[DATA_WIDTH-1:0] : d_add[DATA_WIDTH-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        add_next  = add_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            acc_next  = '0;
            add_next  = a;
            b_next    = b;
            m_next    = m;
            cnt_next  = CW'(DATA_WIDTH);
        end else if (busy_reg) begin
            if (op_reg == mme_pkg::OP_RED) begin
                acc_next = acc_red;
                b_next   = {b_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else if (b_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                acc_next = acc_red;
                add_next = add_red;
                b_next   = {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
        add_reg <= add_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        cnt_reg <= cnt_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ----- dv/tb_modular_exponentiation.sv -----
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    localparam int FW        = 31;                    // width of every operand field
    localparam int IN_BITS   = ((3*FW+7)/8)*8;        // 96: three fields plus padding
    localparam int OUT_BITS  = ((FW+7)/8)*8;          // 32: result plus padding
    localparam int PAD_BITS  = IN_BITS - 3*FW;
    localparam bit [FW-1:0] FIELD_MAX = '1;

    // idling profiles, percent of cycles
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 62;
    localparam int IDLE_BOTH  = 26;

    localparam int PHASE_ITEMS   = 65;
    localparam int HOLD_OFF_LONG = 3000;               // receiver hold-off in cycles
    localparam int DRAIN_CYCLES  = 2200;               // extra wait after the last expected result
    localparam int RUN_LIMIT_NS  = 40_000_000;         // simulation time limit in ns

    typedef struct {
        bit [FW-1:0]       base;
        bit [FW-1:0]       exponent;
        bit [FW-1:0]       modulus;
        bit [PAD_BITS-1:0] pad;
    } operand_set_t;

    typedef struct {
        operand_set_t ops;
        bit [FW-1:0]  power;
    } pending_power_t;

    logic                aclk;
    logic                aresetn;
    logic [IN_BITS-1:0]  s_axis_tdata;   // base, exponent, modulus from bit 0 up, zero padded
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;   // power_result from bit 0 up, zero padded
    logic                m_axis_tvalid;
    logic                m_axis_tready;

    pending_power_t pending_powers[$];
    int             send_idle_pct  = IDLE_NONE;
    int             recv_stall_pct = IDLE_NONE;
    int             hold_off_cycles = 0;
    int             mismatch_count = 0;
    int             beats_sent     = 0;
    int             powers_checked = 0;
    int             zero_exp_seen  = 0;

    modular_exponentiation #(
        .DATA_WIDTH(FW)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // right-to-left square and multiply with exact 64-bit products
    function automatic bit [FW-1:0] mod_power(operand_set_t ops);
        longint unsigned acc;
        longint unsigned square;
        longint unsigned modulus;
        bit [FW-1:0]     exp_left;
        if (ops.modulus == 0) begin
            return '0;
        end
        modulus  = ops.modulus;
        acc      = 1;
        square   = ops.base % modulus;
        exp_left = ops.exponent;
        while (exp_left != 0) begin
            if (exp_left[0]) begin
                acc = (acc * square) % modulus;
            end
            square   = (square * square) % modulus;
            exp_left = exp_left >> 1;
        end
        return acc[FW-1:0];
    endfunction

    // offer one beat, with random idle cycles ahead of it, and log the expected power
    task automatic send_operands(operand_set_t ops);
        pending_power_t entry;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ops.pad, ops.modulus, ops.exponent, ops.base};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        entry.ops   = ops;
        entry.power = mod_power(ops);
        pending_powers.push_back(entry);
        beats_sent++;
        if (ops.exponent == 0) zero_exp_seen++;
    endtask

    function automatic operand_set_t make_ops(bit [FW-1:0] b, bit [FW-1:0] e,
                                              bit [FW-1:0] m, bit [PAD_BITS-1:0] p);
        operand_set_t ops;
        ops.base     = b;
        ops.exponent = e;
        ops.modulus  = m;
        ops.pad      = p;
        return ops;
    endfunction

    // exponent of random bit length, so most items stay short
    function automatic bit [FW-1:0] rand_exponent(int max_len);
        int          len;
        bit [FW-1:0] e;
        len = $urandom_range(max_len, 0);
        if (len == 0) begin
            return '0;
        end
        e = FW'($urandom);
        e = FW'(e & ((FW'(1) << len) - 1));
        e[len-1] = 1'b1;
        return e;
    endfunction

    function automatic operand_set_t rand_ops(int max_exp_len);
        operand_set_t ops;
        int           pick;
        pick = $urandom_range(7);
        ops.base     = FW'($urandom);
        ops.exponent = rand_exponent(max_exp_len);
        ops.pad      = PAD_BITS'($urandom);
        case (pick)
            0: begin
                ops.modulus = FW'($urandom_range(16, 1));
            end
            1: begin
                ops.modulus = FIELD_MAX;
            end
            2: begin
                ops.base    = FW'(FIELD_MAX - $urandom_range(3));
                ops.modulus = FW'($urandom_range(FIELD_MAX, 1));
            end
            default: begin
                ops.modulus = FW'($urandom_range(FIELD_MAX, 1));
            end
        endcase
        return ops;
    endfunction

    // field extremes, reduction of the base, exponent zero and modulus one, modulus zero
    task automatic test_directed();
        send_idle_pct  = IDLE_NONE;
        recv_stall_pct = IDLE_NONE;
        send_operands(make_ops(0, 0, 1, 0));
        send_operands(make_ops(FIELD_MAX, 0, 1, 0));           // exponent zero, modulus one
        send_operands(make_ops(0, 0, FIELD_MAX, 0));
        send_operands(make_ops(FIELD_MAX, FIELD_MAX, FIELD_MAX, 0));
        send_operands(make_ops(FIELD_MAX - 1, FIELD_MAX, FIELD_MAX, 0));
        send_operands(make_ops(2, FIELD_MAX - 1, FIELD_MAX, 0)); // fermat on a prime modulus
        send_operands(make_ops(0, 5, 7, 0));
        send_operands(make_ops(1, FIELD_MAX, 1000003, 0));
        send_operands(make_ops(FIELD_MAX, 3, 2, 0));           // base far above modulus
        send_operands(make_ops(5, 1, 3, 0));
        send_operands(make_ops(12345, 77, 1, 0));              // modulus one, exponent set
        send_operands(make_ops(9, 4, 0, 0));                   // modulus zero
        send_operands(make_ops(0, 0, 0, '1));                  // modulus zero, exponent zero
        send_operands(make_ops(3, 4, 1000, '1));               // padding bits set
        send_operands(make_ops(31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 3'b101));
        send_operands(make_ops(31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 3'b010));
        send_operands(make_ops(7, 31'h4000_0000, FIELD_MAX - 2, 0));
        send_operands(make_ops(FIELD_MAX, 1, FIELD_MAX - 1, 0));
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_operands(rand_ops(FW));
    endtask

    // receiver holds off long enough that the result register and the core fill up
    task automatic test_backpressure();
        send_idle_pct  = IDLE_NONE;
        recv_stall_pct = IDLE_NONE;
        @(negedge aclk);
        hold_off_cycles = HOLD_OFF_LONG;
        repeat (10) send_operands(rand_ops(6));
    endtask

    // receiver: long hold-off first, random stalls otherwise
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each result beat with the oldest expected power
    always @(posedge aclk) begin
        pending_power_t entry;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, got 0x%08h", $time, m_axis_tdata);
            end else begin
                entry = pending_powers.pop_front();
                powers_checked++;
                if (m_axis_tdata !== {{(OUT_BITS-FW){1'b0}}, entry.power}) begin
                    mismatch_count++;
                    $display("%0t: power_result mismatch for base %0d exp %0d mod %0d:",
                             $time, entry.ops.base, entry.ops.exponent, entry.ops.modulus);
                    $display("    expected %0d, got 0x%08h", entry.power, m_axis_tdata);
                end
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(PHASE_ITEMS, IDLE_NONE, IDLE_NONE);
        test_random(PHASE_ITEMS, IDLE_HEAVY, IDLE_NONE);
        test_random(PHASE_ITEMS, IDLE_NONE, IDLE_HEAVY);
        test_random(PHASE_ITEMS, IDLE_BOTH, IDLE_BOTH);
        test_backpressure();

        @(negedge aclk);
        s_axis_tvalid  <= 1'b0;
        recv_stall_pct = IDLE_NONE;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operand beats (%0d with exponent zero), %0d powers compared",
                 beats_sent, zero_exp_seen, powers_checked);
        $display("idling profiles: none, sender heavy, receiver heavy, both, long hold-off");
        if (mismatch_count == 0 && pending_powers.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- modular_exponentiation.f -----
hw/rtl/mme_pkg.sv
hw/rtl/mme_mulmod.sv
hw/rtl/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
